// ===== rtl/dnrs_pkg.sv =====
// Shared constants and types for the directional nearest rectangle selector.
`timescale 1ns / 1ps

package dnrs_pkg;

  localparam int COORD_BITS = 12;
  localparam int ID_BITS    = 8;

  // Rectangle ends never wrap; doubled centers need one more bit.
  localparam int END_BITS = COORD_BITS + 1;
  localparam int SUM_BITS = COORD_BITS + 2;

  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = (COORD_BITS > ID_BITS) ? COORD_BITS : ID_BITS;

  localparam int IN_FIELD_BITS = ID_BITS + 4 * COORD_BITS;
  localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((ID_BITS + 7) / 8) * 8;

  localparam logic [CFG_ADDR_BITS-1:0] REG_SRC_ROW    = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SRC_COL    = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SRC_HEIGHT = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SRC_WIDTH  = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SRC_IDENT  = 3'd4;
  localparam logic [CFG_ADDR_BITS-1:0] REG_DIRECTION  = 3'd5;

  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_e;

  typedef struct packed {
    logic [ID_BITS-1:0]    ident;
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] height;
    logic [COORD_BITS-1:0] width;
    logic                  last;
  } cand_t;

endpackage

// ===== rtl/directional_nearest_rect_select.sv =====
// Top level of the directional nearest rectangle selector.
`timescale 1ns / 1ps

// Candidate rectangles arrive one beat per cycle on the slave stream; each is
// registered, then scored against the source rectangle and direction held in
// the configuration registers and compared with the best score so far in the
// next cycle. The beat with tlast set produces one result beat (tuser = found,
// tdata = winning id, zero when nothing qualified) from the output register,
// and the search restarts. Throughput is one candidate per cycle;
// the input stalls only while a finished result waits in the output register
// and a second last beat is ready to leave the scoring stage.
module directional_nearest_rect_select (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [dnrs_pkg::CFG_ADDR_BITS-1:0]      cfg_addr_i,
  input  logic [dnrs_pkg::CFG_DATA_BITS-1:0]      cfg_wdata_i,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // cand_ident, cand_row, cand_col, cand_height, cand_width, zero pad
  input  logic [dnrs_pkg::IN_DATA_BITS-1:0]       s_axis_tdata,
  input  logic                                    s_axis_tlast,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // best_ident, zero pad
  output logic [dnrs_pkg::OUT_DATA_BITS-1:0]      m_axis_tdata,
  // found
  output logic                                    m_axis_tuser
);
  import dnrs_pkg::*;

  logic [COORD_BITS-1:0] src_row_q, src_col_q, src_height_q, src_width_q;
  logic [ID_BITS-1:0]    src_ident_q;
  dir_e                  direction_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_row_q    <= '0;
      src_col_q    <= '0;
      src_height_q <= '0;
      src_width_q  <= '0;
      src_ident_q  <= '0;
      direction_q  <= DIR_LEFT;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_SRC_ROW:    src_row_q    <= cfg_wdata_i[COORD_BITS-1:0];
        REG_SRC_COL:    src_col_q    <= cfg_wdata_i[COORD_BITS-1:0];
        REG_SRC_HEIGHT: src_height_q <= cfg_wdata_i[COORD_BITS-1:0];
        REG_SRC_WIDTH:  src_width_q  <= cfg_wdata_i[COORD_BITS-1:0];
        REG_SRC_IDENT:  src_ident_q  <= cfg_wdata_i[ID_BITS-1:0];
        REG_DIRECTION:  direction_q  <= dir_e'(cfg_wdata_i[1:0]);
        default: ;
      endcase
    end
  end

  // Input register
  logic  s1_valid_q;
  cand_t s1_q;
  logic  s1_adv;
  logic  m_valid_q;

  assign s1_adv        = s1_valid_q && !(s1_q.last && m_valid_q && !m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_q.ident  <= s_axis_tdata[ID_BITS-1:0];
      s1_q.row    <= s_axis_tdata[ID_BITS +: COORD_BITS];
      s1_q.col    <= s_axis_tdata[ID_BITS + COORD_BITS +: COORD_BITS];
      s1_q.height <= s_axis_tdata[ID_BITS + 2 * COORD_BITS +: COORD_BITS];
      s1_q.width  <= s_axis_tdata[ID_BITS + 3 * COORD_BITS +: COORD_BITS];
      s1_q.last   <= s_axis_tlast;
    end
  end

  // Scoring
  logic [END_BITS-1:0] s_h_beg, s_h_end, s_v_beg, s_v_end;
  logic [END_BITS-1:0] c_h_beg, c_h_end, c_v_beg, c_v_end;
  logic [END_BITS-1:0] p_sb, p_se, p_cb, p_ce;
  logic [END_BITS-1:0] prim, perp;
  logic [SUM_BITS-1:0] s_sum, c_sum, ctr_diff;
  logic                side_ok, horiz, elig, better;

  assign s_h_beg = {1'b0, src_col_q};
  assign s_h_end = {1'b0, src_col_q} + {1'b0, src_width_q};
  assign s_v_beg = {1'b0, src_row_q};
  assign s_v_end = {1'b0, src_row_q} + {1'b0, src_height_q};
  assign c_h_beg = {1'b0, s1_q.col};
  assign c_h_end = {1'b0, s1_q.col} + {1'b0, s1_q.width};
  assign c_v_beg = {1'b0, s1_q.row};
  assign c_v_end = {1'b0, s1_q.row} + {1'b0, s1_q.height};

  always_comb begin
    case (direction_q)
      DIR_LEFT: begin
        side_ok = c_h_end <= s_h_beg;
        prim    = s_h_beg - c_h_end;
      end
      DIR_RIGHT: begin
        side_ok = c_h_beg >= s_h_end;
        prim    = c_h_beg - s_h_end;
      end
      DIR_UP: begin
        side_ok = c_v_end <= s_v_beg;
        prim    = s_v_beg - c_v_end;
      end
      default: begin
        side_ok = c_v_beg >= s_v_end;
        prim    = c_v_beg - s_v_end;
      end
    endcase
  end

  assign horiz = (direction_q == DIR_LEFT) || (direction_q == DIR_RIGHT);
  assign p_sb  = horiz ? s_v_beg : s_h_beg;
  assign p_se  = horiz ? s_v_end : s_h_end;
  assign p_cb  = horiz ? c_v_beg : c_h_beg;
  assign p_ce  = horiz ? c_v_end : c_h_end;

  always_comb begin
    if (p_se < p_cb) begin
      perp = p_cb - p_se;
    end else if (p_ce < p_sb) begin
      perp = p_sb - p_ce;
    end else begin
      perp = '0;
    end
  end

  assign s_sum    = {1'b0, p_sb} + {1'b0, p_se};
  assign c_sum    = {1'b0, p_cb} + {1'b0, p_ce};
  assign ctr_diff = (s_sum >= c_sum) ? (s_sum - c_sum) : (c_sum - s_sum);

  // Best so far
  logic                have_best_q;
  logic [ID_BITS-1:0]  best_id_q;
  logic [END_BITS-1:0] best_prim_q, best_perp_q;
  logic [SUM_BITS-1:0] best_dist_q;
  logic                take, have_new;
  logic [ID_BITS-1:0]  id_new;

  assign elig = (s1_q.ident != src_ident_q) && (s1_q.height != '0) &&
                (s1_q.width != '0) && side_ok;
  assign better = !have_best_q || (prim < best_prim_q) ||
                  ((prim == best_prim_q) && (perp < best_perp_q)) ||
                  ((prim == best_prim_q) && (perp == best_perp_q) &&
                   (ctr_diff < best_dist_q));
  assign take     = elig && better;
  assign have_new = have_best_q || take;
  assign id_new   = take ? s1_q.ident : best_id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_best_q <= 1'b0;
    end else if (s1_adv) begin
      have_best_q <= s1_q.last ? 1'b0 : have_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && take) begin
      best_id_q   <= s1_q.ident;
      best_prim_q <= prim;
      best_perp_q <= perp;
      best_dist_q <= ctr_diff;
    end
  end

  // Output register
  logic                found_q;
  logic [ID_BITS-1:0]  out_id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s1_adv && s1_q.last) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_q.last) begin
      found_q  <= have_new;
      out_id_q <= have_new ? id_new : '0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = found_q;
  assign m_axis_tdata  = OUT_DATA_BITS'(out_id_q);

endmodule

// ===== rtl/dnrs_checker.sv =====
// Port-level assertions for the directional nearest rectangle selector.
`timescale 1ns / 1ps

module dnrs_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               s_axis_tlast,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [dnrs_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
  input logic                               m_axis_tuser
);
  import dnrs_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // no winner means id zero
  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("nonzero id without found");

  // a fresh result follows an accepted last beat
  a_rose_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |->
      $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
    else $error("result without last beat");

  // input backpressure only from a blocked result
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without blocked output");

endmodule

bind directional_nearest_rect_select dnrs_checker u_dnrs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
